// File: rtl/rrgd_pkg.sv
// ============================================================================
// rrgd_pkg: shared types and constants
// Widths, command and status codes, and the sequencer state type for the
// round-robin gather and flow demultiplexer.
// ============================================================================
package rrgd_pkg;

  localparam int QueueDepth     = 16;
  localparam int MaxInputPorts  = 8;
  localparam int MaxOutputPorts = 8;
  localparam int PtrW   = $clog2(QueueDepth);
  localparam int FillW  = $clog2(QueueDepth + 1);
  localparam int PortW  = 3;
  localparam int SlotW  = PortW + PtrW;

  typedef logic [47:0] pkt_t;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_ROUND = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  localparam logic [1:0] REG_IN_COUNT  = 2'd0;
  localparam logic [1:0] REG_OUT_COUNT = 2'd1;
  localparam logic [1:0] REG_QUOTA     = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_PUSH, S_POPRD, S_POPWT, S_GCHK, S_GRD, S_GWR,
    S_DCHK, S_DRD, S_DMOD, S_DWR, S_DONE
  } state_t;

  // Clamp a configured port count to 1..max.
  function automatic logic [3:0] eff_count(input logic [3:0] v, input logic [3:0] maxv);
    logic [3:0] r;
    r = v;
    if (v == 4'd0) r = 4'd1;
    else if (v > maxv) r = maxv;
    return r;
  endfunction

endpackage

// File: rtl/rrgd_mem.sv
// ============================================================================
// rrgd_mem: packet store
// Single write port, single registered read port RAM.
// ============================================================================
module rrgd_mem #(
  parameter int Depth = 16,
  parameter int AddrW = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [47:0]      wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [47:0]      rdata
);
  logic [47:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/rrgd_mod.sv
// ============================================================================
// rrgd_mod: flow modulo unit
// Reduces a flow number modulo the output count by restoring subtraction,
// one bit a cycle.
// ============================================================================
module rrgd_mod
  import rrgd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [15:0] flow,
  input  logic [3:0]  divisor,
  output logic        done,
  output logic [2:0]  rem
);
  logic [15:0] shreg;
  logic [3:0]  part;
  logic [4:0]  cnt;
  logic        busy;
  logic [4:0]  trial;

  assign trial = {part, shreg[15]} - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= 5'd16;
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      shreg <= flow;
      part  <= '0;
    end else if (busy) begin
      shreg <= {shreg[14:0], 1'b0};
      // Remainder stays below the divisor, so it fits four bits.
      if (!trial[4]) part <= trial[3:0];
      else part <= {part[2:0], shreg[15]};
    end
  end

  assign rem = part[2:0];
endmodule

// File: rtl/round_robin_gather_flow_demux_core.sv
// ============================================================================
// round_robin_gather_flow_demux_core: quota gather and flow demultiplexer
// Eight input FIFOs, one central FIFO and eight output FIFOs of packets,
// driven by push, pop and service-round commands.
// ============================================================================
// Usage: a command transfer is taken when start is high and busy is low.
// Exactly one result follows, shown for one cycle while done is high; the
// receiver cannot stall it. The user must write registers over the APB
// port only while the block is idle; the block itself does not enforce it.
// A service round runs one sequencer over the packet stores: it gathers
// up to quota packets from each input FIFO in port order into the
// central FIFO, then drains each packet through the bit-serial modulo
// unit into the output FIFO that its flow number selects.
// busy is high from the cycle after acceptance up to the result cycle; it
// is already low while done is high, so the next command can be taken in
// the result cycle.
// Reset clears all FIFO pointers and fill counts and loads the register
// defaults (8 inputs, 8 outputs, quota 2); store contents are not cleared.
// ============================================================================
module round_robin_gather_flow_demux_core
  import rrgd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [2:0]  port,
  input  logic [15:0] flow_id,
  input  logic [31:0] order_num,
  output logic        done,
  output logic [1:0]  status,
  output logic        popped_valid,
  output logic [15:0] popped_flow,
  output logic [31:0] popped_order,
  output logic [4:0]  gathered_count,
  output logic [4:0]  passed_count,
  output logic        drain_blocked
);
  logic [3:0] in_count, out_count;
  logic [4:0] quota;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_count  <= 4'd8;
      out_count <= 4'd8;
      quota     <= 5'd2;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_IN_COUNT:  in_count  <= pwdata[3:0];
        REG_OUT_COUNT: out_count <= pwdata[3:0];
        REG_QUOTA:     quota     <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_IN_COUNT:  prdata = {28'd0, in_count};
      REG_OUT_COUNT: prdata = {28'd0, out_count};
      REG_QUOTA:     prdata = {27'd0, quota};
      default:       prdata = '0;
    endcase
  end

  logic [3:0] n_in, n_out;
  assign n_in  = eff_count(in_count, 4'(MaxInputPorts));
  assign n_out = eff_count(out_count, 4'(MaxOutputPorts));

  // FIFO pointers; one entry per port, indexed by the sequencer.
  logic [PtrW-1:0]  in_head [MaxInputPorts];
  logic [PtrW-1:0]  in_tail [MaxInputPorts];
  logic [FillW-1:0] in_fill [MaxInputPorts];
  logic [PtrW-1:0]  out_head [MaxOutputPorts];
  logic [PtrW-1:0]  out_tail [MaxOutputPorts];
  logic [FillW-1:0] out_fill [MaxOutputPorts];
  logic [PtrW-1:0]  c_head, c_tail;
  logic [FillW-1:0] c_fill;

  state_t state, state_next;

  logic [2:0]  port_r;
  logic [47:0] pkt_r;
  logic [2:0]  gport;
  logic [4:0]  taken;
  logic [2:0]  q_r;

  // Store ports.
  logic         in_we, c_we, out_we;
  logic [SlotW-1:0] in_waddr, in_raddr, out_waddr, out_raddr;
  logic [PtrW-1:0]  c_waddr, c_raddr;
  logic [47:0]  in_wdata, out_wdata, in_rdata, c_rdata, out_rdata;

  rrgd_mem #(.Depth(MaxInputPorts * QueueDepth), .AddrW(SlotW)) u_in_mem (
    .clk, .we(in_we), .waddr(in_waddr), .wdata(in_wdata),
    .raddr(in_raddr), .rdata(in_rdata));
  rrgd_mem #(.Depth(QueueDepth), .AddrW(PtrW)) u_c_mem (
    .clk, .we(c_we), .waddr(c_waddr), .wdata(in_rdata),
    .raddr(c_raddr), .rdata(c_rdata));
  rrgd_mem #(.Depth(MaxOutputPorts * QueueDepth), .AddrW(SlotW)) u_out_mem (
    .clk, .we(out_we), .waddr(out_waddr), .wdata(out_wdata),
    .raddr(out_raddr), .rdata(out_rdata));

  logic       mod_go, mod_done;
  logic [2:0] mod_rem;

  rrgd_mod u_mod (
    .clk, .rst, .go(mod_go), .flow(c_rdata[47:32]), .divisor(n_out),
    .done(mod_done), .rem(mod_rem));

  assign in_wdata  = pkt_r;
  assign out_wdata = c_rdata;
  assign in_waddr  = {port_r, in_tail[port_r]};
  assign in_raddr  = {gport, in_head[gport]};
  assign c_waddr   = c_tail;
  assign c_raddr   = c_head;
  assign out_waddr = {q_r, out_tail[q_r]};
  assign out_raddr = {port_r, out_head[port_r]};

  logic c_full, g_more, last_port;
  assign c_full    = (c_fill == FillW'(QueueDepth));
  assign g_more    = (taken < quota) && (in_fill[gport] != '0);
  assign last_port = ({1'b0, gport} == n_in - 4'd1);

  always_comb begin
    state_next = state;
    in_we  = 1'b0;
    c_we   = 1'b0;
    out_we = 1'b0;
    mod_go = 1'b0;
    unique case (state)
      S_IDLE:  if (start) state_next = state_t'(
                 (command == CMD_PUSH) ? S_PUSH :
                 (command == CMD_POP)  ? S_POPRD :
                 (command == CMD_ROUND) ? S_GCHK : S_DONE);
      S_PUSH: begin
        in_we = ({1'b0, port_r} < n_in) && (in_fill[port_r] != FillW'(QueueDepth));
        state_next = S_DONE;
      end
      S_POPRD: state_next = S_POPWT;
      S_POPWT: state_next = S_DONE;
      S_GCHK: begin
        if (c_full) state_next = S_DCHK;
        else if (g_more) state_next = S_GRD;
        else if (last_port) state_next = S_DCHK;
        else state_next = S_GCHK;
      end
      S_GRD: state_next = S_GWR;
      S_GWR: begin
        c_we = 1'b1;
        state_next = S_GCHK;
      end
      S_DCHK: state_next = (c_fill == '0) ? S_DONE : S_DRD;
      S_DRD: begin
        mod_go = 1'b1;
        state_next = S_DMOD;
      end
      S_DMOD: if (mod_done) state_next = S_DWR;
      S_DWR: begin
        if (out_fill[q_r] == FillW'(QueueDepth)) state_next = S_DONE;
        else begin
          out_we = 1'b1;
          state_next = S_DCHK;
        end
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      port_r <= port;
      pkt_r  <= {flow_id, order_num};
    end
    if (mod_done) q_r <= mod_rem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MaxInputPorts; i++) begin
        in_head[i] <= '0;
        in_tail[i] <= '0;
        in_fill[i] <= '0;
      end
      for (int i = 0; i < MaxOutputPorts; i++) begin
        out_head[i] <= '0;
        out_tail[i] <= '0;
        out_fill[i] <= '0;
      end
      c_head <= '0;
      c_tail <= '0;
      c_fill <= '0;
      gport <= '0;
      taken <= '0;
      done  <= 1'b0;
      status <= ST_OK;
      popped_valid <= 1'b0;
      popped_flow  <= '0;
      popped_order <= '0;
      gathered_count <= '0;
      passed_count   <= '0;
      drain_blocked  <= 1'b0;
    end else begin
      done <= (state == S_DONE);
      if (state == S_IDLE && start) begin
        gport <= '0;
        taken <= '0;
        status <= ST_OK;
        popped_valid <= 1'b0;
        popped_flow  <= '0;
        popped_order <= '0;
        gathered_count <= '0;
        passed_count   <= '0;
        drain_blocked  <= 1'b0;
      end
      unique case (state)
        S_PUSH: begin
          if ({1'b0, port_r} >= n_in) status <= ST_RANGE;
          else if (in_fill[port_r] == FillW'(QueueDepth)) status <= ST_FULL;
          else begin
            in_tail[port_r] <= in_tail[port_r] + 1'b1;
            in_fill[port_r] <= in_fill[port_r] + 1'b1;
          end
        end
        S_POPRD: begin
          if ({1'b0, port_r} >= n_out) status <= ST_RANGE;
          else if (out_fill[port_r] == '0) status <= ST_EMPTY;
        end
        S_POPWT: begin
          if (({1'b0, port_r} < n_out) && (out_fill[port_r] != '0)) begin
            popped_valid <= 1'b1;
            popped_flow  <= out_rdata[47:32];
            popped_order <= out_rdata[31:0];
            out_head[port_r] <= out_head[port_r] + 1'b1;
            out_fill[port_r] <= out_fill[port_r] - 1'b1;
          end
        end
        S_GCHK: begin
          if (!c_full && !g_more && !last_port) begin
            gport <= gport + 3'd1;
            taken <= '0;
          end
        end
        S_GWR: begin
          in_head[gport] <= in_head[gport] + 1'b1;
          in_fill[gport] <= in_fill[gport] - 1'b1;
          c_tail <= c_tail + 1'b1;
          c_fill <= c_fill + 1'b1;
          taken  <= taken + 5'd1;
          gathered_count <= gathered_count + 5'd1;
        end
        S_DWR: begin
          if (out_fill[q_r] == FillW'(QueueDepth)) drain_blocked <= 1'b1;
          else begin
            out_tail[q_r] <= out_tail[q_r] + 1'b1;
            out_fill[q_r] <= out_fill[q_r] + 1'b1;
            c_head <= c_head + 1'b1;
            c_fill <= c_fill - 1'b1;
            passed_count <= passed_count + 5'd1;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// File: rtl/rrgd_checker.sv
// ============================================================================
// rrgd_checker: port-level checks
// Watches the command and result ports of the top level over time.
// ============================================================================
module rrgd_checker
  import rrgd_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic       popped_valid,
  input logic [1:0] status,
  input logic       drain_blocked,
  input logic [4:0] gathered_count,
  input logic [4:0] passed_count
);
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("busy did not rise after a transfer");
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result held longer than one cycle");
  a_pop_ok: assert property (@(posedge clk) disable iff (rst)
    done && popped_valid |-> status == ST_OK) else $error("popped with bad status");
  a_counts: assert property (@(posedge clk) disable iff (rst)
    done |-> gathered_count <= 5'd16 && passed_count <= 5'd16)
    else $error("round count out of range");
  a_blocked: assert property (@(posedge clk) disable iff (rst)
    done && drain_blocked |-> !popped_valid) else $error("blocked with pop");
endmodule

bind round_robin_gather_flow_demux_core rrgd_checker u_rrgd_checker (
  .clk, .rst, .start, .busy, .done, .popped_valid, .status, .drain_blocked,
  .gathered_count, .passed_count);
